// ===== hw/rtl/bmp_pkg.sv =====
// Shared constants, codes and types for the bitmap to RGB565 converter.
package bmp_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int PAL_DEPTH  = 256;
	localparam int PAL_AW     = $clog2(PAL_DEPTH);

	localparam int DIM_W = 12;
	localparam int CRD_W = 11;
	localparam int COL_W = 16;

	localparam logic [1:0] REG_DEPTH_MODE   = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	localparam logic [1:0] MODE_24   = 2'd0;
	localparam logic [1:0] MODE_8    = 2'd1;
	localparam logic [1:0] MODE_4    = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_DATA    = 1'b1;

	typedef struct packed {
		logic             valid;
		logic             two;
		logic             use_pal;
		logic             ok0;
		logic [COL_W-1:0] direct;
		logic [CRD_W-1:0] col;
		logic [CRD_W-1:0] row;
		logic             done0;
		logic             done1;
	} s1_t;

	typedef struct packed {
		logic [COL_W-1:0] color;
		logic [CRD_W-1:0] col;
		logic [CRD_W-1:0] row;
		logic             last;
		logic             done;
	} res_t;

	function automatic logic [COL_W-1:0] pack565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		pack565 = {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// ===== hw/rtl/bmp_pixels_to_rgb565.sv =====
// Top level: bottom-up bitmap byte stream to RGB565 pixels with coordinates.
//
// Write depth_mode, image_width and image_height, then the palette entries
// (kind 0), then the pixel data bytes (kind 1) in file order. Every accepted
// byte is registered in the first stage with its palette read; any result
// words then move into the output buffer. In 24-bit and 8-bit modes one byte
// is taken every cycle while out_stall is low. In 4-bit mode a byte yields up
// to two words and the single output port sets the pace: a new byte waits
// for the buffer to drain. The palette is a 256-entry memory with two
// registered read ports, read once per data byte; a palette write is visible
// to the very next byte. Palette entries must be written before bytes refer
// to them. After the last row's padding the next byte starts a new image.
module bmp_pixels_to_rgb565 (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [bmp_pkg::DIM_W-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [7:0]                 palette_index,
	input  logic [7:0]                 palette_blue,
	input  logic [7:0]                 palette_green,
	input  logic [7:0]                 palette_red,
	input  logic [7:0]                 data_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [15:0]                pixel_color,
	output logic [10:0]                column,
	output logic [10:0]                row,
	output logic                       last_of_run,
	output logic                       image_done
);
	import bmp_pkg::*;

	s1_t               s1;
	res_t              res;
	logic              load_ok;
	logic              pal_we;
	logic [PAL_AW-1:0] pal_waddr;
	logic [COL_W-1:0]  pal_wdata;
	logic              pal_re;
	logic [PAL_AW-1:0] pal_raddr0;
	logic [PAL_AW-1:0] pal_raddr1;
	logic [COL_W-1:0]  pal_rdata0;
	logic [COL_W-1:0]  pal_rdata1;

	assign in_stall = s1.valid && !load_ok;

	bmp_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.palette_index (palette_index),
		.palette_blue  (palette_blue),
		.palette_green (palette_green),
		.palette_red   (palette_red),
		.data_byte     (data_byte),
		.s1            (s1),
		.pal_we        (pal_we),
		.pal_waddr     (pal_waddr),
		.pal_wdata     (pal_wdata),
		.pal_re        (pal_re),
		.pal_raddr0    (pal_raddr0),
		.pal_raddr1    (pal_raddr1)
	);

	bmp_palette u_palette (
		.clk    (clk),
		.we     (pal_we),
		.waddr  (pal_waddr),
		.wdata  (pal_wdata),
		.re     (pal_re),
		.raddr0 (pal_raddr0),
		.raddr1 (pal_raddr1),
		.rdata0 (pal_rdata0),
		.rdata1 (pal_rdata1)
	);

	bmp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.rdata0    (pal_rdata0),
		.rdata1    (pal_rdata1),
		.out_stall (out_stall),
		.load_ok   (load_ok),
		.out_valid (out_valid),
		.res       (res)
	);

	assign pixel_color = res.color;
	assign column      = res.col;
	assign row         = res.row;
	assign last_of_run = res.last;
	assign image_done  = res.done;

endmodule

// ===== hw/rtl/bmp_palette.sv =====
// Palette memory: one write port, two registered read ports.
module bmp_palette (
	input  logic                         clk,
	input  logic                         we,
	input  logic [bmp_pkg::PAL_AW-1:0]   waddr,
	input  logic [bmp_pkg::COL_W-1:0]    wdata,
	input  logic                         re,
	input  logic [bmp_pkg::PAL_AW-1:0]   raddr0,
	input  logic [bmp_pkg::PAL_AW-1:0]   raddr1,
	output logic [bmp_pkg::COL_W-1:0]    rdata0,
	output logic [bmp_pkg::COL_W-1:0]    rdata1
);
	import bmp_pkg::*;

	logic [COL_W-1:0] mem [PAL_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

// ===== hw/rtl/bmp_seq.sv =====
// Configuration registers, row and pixel tracking, palette access and first stage.
module bmp_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [bmp_pkg::DIM_W-1:0]   cfg_data,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        kind,
	input  logic [7:0]                  palette_index,
	input  logic [7:0]                  palette_blue,
	input  logic [7:0]                  palette_green,
	input  logic [7:0]                  palette_red,
	input  logic [7:0]                  data_byte,
	output bmp_pkg::s1_t                s1,
	output logic                        pal_we,
	output logic [bmp_pkg::PAL_AW-1:0]  pal_waddr,
	output logic [bmp_pkg::COL_W-1:0]   pal_wdata,
	output logic                        pal_re,
	output logic [bmp_pkg::PAL_AW-1:0]  pal_raddr0,
	output logic [bmp_pkg::PAL_AW-1:0]  pal_raddr1
);
	import bmp_pkg::*;

	logic [1:0]        depth_mode_q;
	logic [DIM_W-1:0]  image_width_q;
	logic [DIM_W-1:0]  image_height_q;
	logic [13:0]       byte_in_row_q;
	logic [CRD_W-1:0]  file_row_q;
	logic [DIM_W-1:0]  pixel_in_row_q;
	logic [COL_W-1:0]  partial_q;
	logic [1:0]        phase_q;
	s1_t               s1_q;
	logic              s1_valid_q;

	logic [DIM_W-1:0]  w;
	logic [DIM_W-1:0]  h;
	logic [CRD_W-1:0]  fr;
	logic [13:0]       stride;
	logic [13:0]       w3;
	logic [DIM_W-1:0]  half_w;
	logic [13:0]       bir_n;
	logic              row_end;
	logic [DIM_W:0]    pir1;
	logic              e0;
	logic              e1;
	logic              accept;
	logic              data_go;
	logic [DIM_W:0]    fr1;
	logic [DIM_W-1:0]  pir_d;
	logic [COL_W-1:0]  partial_d;
	logic [1:0]        phase_d;
	logic [COL_W-1:0]  direct;
	logic [DIM_W-1:0]  row_full;

	assign accept  = in_valid && !in_stall;
	assign data_go = accept && (kind == KIND_DATA) && (depth_mode_q != MODE_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_mode_q   <= MODE_24;
			image_width_q  <= DIM_W'(1);
			image_height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEPTH_MODE:   depth_mode_q   <= cfg_data[1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (image_width_q == '0)
			w = DIM_W'(1);
		else if (image_width_q > DIM_W'(MAX_WIDTH))
			w = DIM_W'(MAX_WIDTH);
		else
			w = image_width_q;
		if (image_height_q == '0)
			h = DIM_W'(1);
		else if (image_height_q > DIM_W'(MAX_HEIGHT))
			h = DIM_W'(MAX_HEIGHT);
		else
			h = image_height_q;

		fr = ({1'b0, file_row_q} >= h) ? '0 : file_row_q;

		w3     = {1'b0, w, 1'b0} + {2'b00, w} + 14'd3;
		half_w = DIM_W'(({1'b0, w} + 13'd1) >> 1);
		case (depth_mode_q)
			MODE_24: stride = {w3[13:2], 2'b00};
			MODE_8:  stride = ({2'b00, w} + 14'd3) & 14'h3FFC;
			default: stride = ({2'b00, half_w} + 14'd3) & 14'h3FFC;
		endcase

		bir_n   = byte_in_row_q + 14'd1;
		row_end = bir_n >= stride;
		pir1    = {1'b0, pixel_in_row_q} + 13'd1;

		phase_d   = phase_q;
		partial_d = partial_q;
		direct    = '0;
		e0        = 1'b0;
		e1        = 1'b0;
		case (depth_mode_q)
			MODE_24: begin
				if (pixel_in_row_q < w) begin
					case (phase_q)
						2'd0: begin
							partial_d = {11'd0, data_byte[7:3]};
							phase_d   = 2'd1;
						end
						2'd1: begin
							partial_d = partial_q | {5'd0, data_byte[7:2], 5'd0};
							phase_d   = 2'd2;
						end
						default: begin
							direct    = partial_q | {data_byte[7:3], 11'd0};
							partial_d = '0;
							phase_d   = 2'd0;
							e0        = 1'b1;
						end
					endcase
				end
			end
			MODE_8: e0 = pixel_in_row_q < w;
			default: begin
				e0 = pixel_in_row_q < w;
				e1 = e0 && (pir1 < {1'b0, w});
			end
		endcase

		fr1 = {2'b00, fr} + 13'd1;
		if (row_end)
			pir_d = '0;
		else if (e1)
			pir_d = pir1[DIM_W-1:0] + DIM_W'(1);
		else if (e0)
			pir_d = pir1[DIM_W-1:0];
		else
			pir_d = pixel_in_row_q;

		row_full = h - DIM_W'(1) - {1'b0, fr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_row_q  <= '0;
			file_row_q     <= '0;
			pixel_in_row_q <= '0;
			partial_q      <= '0;
			phase_q        <= '0;
		end else if (data_go) begin
			pixel_in_row_q <= pir_d;
			if (row_end) begin
				byte_in_row_q <= '0;
				partial_q     <= '0;
				phase_q       <= '0;
				file_row_q    <= (fr1 >= {1'b0, h}) ? '0 : fr1[CRD_W-1:0];
			end else begin
				byte_in_row_q <= bir_n;
				partial_q     <= partial_d;
				phase_q       <= phase_d;
				file_row_q    <= fr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= data_go && e0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_go) begin
			s1_q.valid   <= 1'b0;
			s1_q.two     <= e1;
			s1_q.use_pal <= depth_mode_q != MODE_24;
			s1_q.ok0     <= (depth_mode_q == MODE_4) || ({1'b0, data_byte} < 9'(PAL_DEPTH));
			s1_q.direct  <= direct;
			s1_q.col     <= pixel_in_row_q[CRD_W-1:0];
			s1_q.row     <= row_full[CRD_W-1:0];
			s1_q.done0   <= ({1'b0, fr} == h - DIM_W'(1)) && (pixel_in_row_q == w - DIM_W'(1));
			s1_q.done1   <= ({1'b0, fr} == h - DIM_W'(1)) &&
				(pir1 == {1'b0, w} - 13'd1);
		end
	end

	always_comb begin
		s1       = s1_q;
		s1.valid = s1_valid_q;
	end

	assign pal_we    = accept && (kind == KIND_PALETTE) &&
		({1'b0, palette_index} < 9'(PAL_DEPTH));
	assign pal_waddr = palette_index[PAL_AW-1:0];
	assign pal_wdata = pack565(palette_red, palette_green, palette_blue);
	assign pal_re    = data_go;
	assign pal_raddr0 = (depth_mode_q == MODE_4) ? PAL_AW'(data_byte[7:4])
		: data_byte[PAL_AW-1:0];
	assign pal_raddr1 = PAL_AW'(data_byte[3:0]);

endmodule

// ===== hw/rtl/bmp_obuf.sv =====
// Output buffer: two result slots, drained one word per handshake.
module bmp_obuf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bmp_pkg::s1_t               s1,
	input  logic [bmp_pkg::COL_W-1:0]  rdata0,
	input  logic [bmp_pkg::COL_W-1:0]  rdata1,
	input  logic                       out_stall,
	output logic                       load_ok,
	output logic                       out_valid,
	output bmp_pkg::res_t              res
);
	import bmp_pkg::*;

	logic [1:0] cnt_q;
	res_t       r0_q;
	res_t       r1_q;
	res_t       n0;
	res_t       n1;
	logic       pop;
	logic       load;

	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && !out_stall;
	assign load_ok   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign load      = s1.valid && load_ok;

	always_comb begin
		n0.color = s1.use_pal ? (s1.ok0 ? rdata0 : '0) : s1.direct;
		n0.col   = s1.col;
		n0.row   = s1.row;
		n0.last  = !s1.two;
		n0.done  = s1.done0;
		n1.color = rdata1;
		n1.col   = s1.col + CRD_W'(1);
		n1.row   = s1.row;
		n1.last  = 1'b1;
		n1.done  = s1.done1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= s1.two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= n0;
			r1_q <= n1;
		end else if (pop && cnt_q == 2'd2) begin
			r0_q <= r1_q;
		end
	end

	assign res = r0_q;

endmodule
